### rtl/atcfc_pkg.sv
// Package for the ARM/Thumb control-flow predecoder.
// Holds the event kind encoding shared by the decoder, the target unit and the top level.
// No dependencies.
`default_nettype none

package atcfc_pkg;

  typedef enum logic [3:0] {
    KIND_ARM_B        = 4'd0,
    KIND_ARM_BL       = 4'd1,
    KIND_ARM_BX       = 4'd2,
    KIND_ARM_LDR_PC   = 4'd3,
    KIND_ARM_LDM_PC   = 4'd4,
    KIND_ARM_ALU_PC   = 4'd5,
    KIND_THUMB_B      = 4'd6,
    KIND_THUMB_BCOND  = 4'd7,
    KIND_BL_PREFIX    = 4'd8,
    KIND_THUMB_BL     = 4'd9,
    KIND_THUMB_BX     = 4'd10,
    KIND_MOV_PC       = 4'd11,
    KIND_ADD_PC       = 4'd12,
    KIND_POP_PC       = 4'd13,
    KIND_SWI          = 4'd14,
    KIND_UNDEF        = 4'd15
  } kind_e;

  localparam logic [31:0] ArmPcOffset   = 32'd8;
  localparam logic [31:0] ThumbPcOffset = 32'd4;

endpackage

`default_nettype wire

### rtl/atcfc_decode.sv
// Instruction classifier: mask/match pattern tables for ARM and Thumb words.
// Depends on atcfc_pkg.
`default_nettype none

module atcfc_decode
  import atcfc_pkg::*;
(
  input  wire logic        cmd_i,
  input  wire logic        patched_i,
  input  wire logic [31:0] insn_word_i,
  output kind_e            kind_o
);

  logic [31:0] w;
  logic [15:0] h;
  kind_e       arm_kind;
  kind_e       thumb_kind;

  assign w = insn_word_i;
  assign h = insn_word_i[15:0];

  always_comb begin
    arm_kind = KIND_UNDEF;
    priority if ((!patched_i && (w & 32'h0E00_0000) == 32'h0A00_0000) ||
                 ( patched_i && (w & 32'h0E00_0000) == 32'h0C00_0000)) begin
      arm_kind = w[24] ? KIND_ARM_BL : KIND_ARM_B;
    end else if ((!patched_i && (w & 32'h0FFF_FFF0) == 32'h012F_FF10) ||
                 ( patched_i && (w & 32'h0FFF_FFF0) == 32'h01B0_0090)) begin
      arm_kind = KIND_ARM_BX;
    end else if ((!patched_i && (w & 32'h0E10_8000) == 32'h0810_8000) ||
                 ( patched_i && (w & 32'h0E50_0010) == 32'h0640_0010)) begin
      arm_kind = KIND_ARM_LDM_PC;
    end else if ((!patched_i && (w & 32'h0C50_F000) == 32'h0410_F000) ||
                 ( patched_i && (w & 32'h0F90_0810) == 32'h0E80_0010)) begin
      arm_kind = KIND_ARM_LDR_PC;
    end else if ((!patched_i && ((w & 32'h0E00_F010) == 32'h0000_F000 ||
                                 (w & 32'h0E00_F010) == 32'h0000_F010 ||
                                 (w & 32'h0E00_F000) == 32'h0200_F000)) ||
                 ( patched_i && (w & 32'h0E00_0000) == 32'h0E00_0000)) begin
      arm_kind = KIND_ARM_ALU_PC;
    end else if ((w & 32'h0F00_0000) == 32'h0F00_0000) begin
      arm_kind = KIND_SWI;
    end else begin
      arm_kind = KIND_UNDEF;
    end
  end

  always_comb begin
    thumb_kind = KIND_UNDEF;
    if (!patched_i) begin
      priority if ((h & 16'hF000) == 16'hD000) thumb_kind = KIND_THUMB_BCOND;
      else if ((h & 16'hF800) == 16'hE000) thumb_kind = KIND_THUMB_B;
      else if ((h & 16'hF800) == 16'hF000) thumb_kind = KIND_BL_PREFIX;
      else if ((h & 16'hF800) == 16'hF800) thumb_kind = KIND_THUMB_BL;
      else if ((h & 16'hFF87) == 16'h4700) thumb_kind = KIND_THUMB_BX;
      else if ((h & 16'hFF87) == 16'h4487) thumb_kind = KIND_ADD_PC;
      else if ((h & 16'hFF87) == 16'h4687) thumb_kind = KIND_MOV_PC;
      else if ((h & 16'hFF00) == 16'hBD00) thumb_kind = KIND_POP_PC;
      else if ((h & 16'hFF00) == 16'hDF00) thumb_kind = KIND_SWI;
      else thumb_kind = KIND_UNDEF;
    end else begin
      priority if ((h & 16'hFF80) == 16'hBB80) thumb_kind = KIND_POP_PC;
      else if ((h & 16'hFA00) == 16'hB200) thumb_kind = KIND_THUMB_B;
      else if ((h & 16'hF801) == 16'hE801) thumb_kind = KIND_THUMB_BL;
      else if ((h & 16'hFC00) == 16'hB800) thumb_kind = KIND_THUMB_BCOND;
      else if ((h & 16'hFF0F) == 16'hB100) thumb_kind = KIND_THUMB_BX;
      else if ((h & 16'hFF0F) == 16'hDE00) thumb_kind = KIND_MOV_PC;
      else if ((h & 16'hFF0F) == 16'hBF00) thumb_kind = KIND_ADD_PC;
      else thumb_kind = KIND_UNDEF;
    end
  end

  assign kind_o = cmd_i ? thumb_kind : arm_kind;

endmodule

`default_nettype wire

### rtl/atcfc_target.sv
// Branch target unit: offset sign-extension, a three-input add, ROM mirror folding.
// Depends on atcfc_pkg.
`default_nettype none

module atcfc_target
  import atcfc_pkg::*;
(
  input  wire logic        cmd_i,
  input  wire logic        patched_i,
  input  wire logic [31:0] insn_word_i,
  input  wire logic [31:0] source_pc_i,
  input  kind_e            kind_i,
  output logic      [31:0] target_o
);

  logic [31:0] base;
  logic [31:0] offset;
  logic [31:0] pc_inc;
  logic [31:0] sum;
  logic [31:0] folded;
  logic        enable;
  logic        thumb;

  always_comb begin
    base   = source_pc_i;
    offset = '0;
    pc_inc = ArmPcOffset;
    enable = 1'b0;
    thumb  = 1'b0;
    if (!patched_i) begin
      if (!cmd_i) begin
        if (kind_i == KIND_ARM_B || kind_i == KIND_ARM_BL) begin
          enable = 1'b1;
          offset = {{6{insn_word_i[23]}}, insn_word_i[23:0], 2'b00};
        end
      end else begin
        base   = {source_pc_i[31:1], 1'b0};
        pc_inc = ThumbPcOffset;
        thumb  = 1'b1;
        if (kind_i == KIND_THUMB_BCOND) begin
          enable = 1'b1;
          offset = {{23{insn_word_i[7]}}, insn_word_i[7:0], 1'b0};
        end else if (kind_i == KIND_THUMB_B) begin
          enable = 1'b1;
          offset = {{20{insn_word_i[10]}}, insn_word_i[10:0], 1'b0};
        end
      end
    end
  end

  assign sum = base + offset + pc_inc;

  // 0x0800_0000..0x0DFF_FFFF folds onto the first ROM mirror
  always_comb begin
    folded = sum;
    if (sum[31:28] == 4'h0 && sum[27] && sum[26:25] != 2'b11) begin
      folded = {sum[31:27], 2'b00, sum[24:0]};
    end
  end

  assign target_o = enable ? (folded | {31'd0, thumb}) : '0;

endmodule

`default_nettype wire

### rtl/arm_thumb_control_flow_classifier_core.sv
// ARM/Thumb control-flow predecoder top level: request register, decode and target, result register.
// Result path: a taken request is held in the request register, then the result register raises the strobe.
// Throughput: one request per cycle; busy_o is never raised.
// Reset: rst_ni asynchronous active low clears both valid flags; the receiver cannot stall.
// Depends on atcfc_pkg, atcfc_decode, atcfc_target.
`default_nettype none

module arm_thumb_control_flow_classifier_core
  import atcfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        cmd_i,
  input  wire logic        patched_i,
  input  wire logic [31:0] insn_word_i,
  input  wire logic [31:0] source_pc_i,
  output logic             done_o,
  output logic      [3:0]  event_kind_o,
  output logic      [31:0] branch_target_o
);

  logic        req_valid_q;
  logic        cmd_q;
  logic        patched_q;
  logic [31:0] insn_q;
  logic [31:0] pc_q;

  logic        res_valid_q;
  kind_e       kind_q;
  kind_e       kind_d;
  logic [31:0] target_q;
  logic [31:0] target_d;

  logic        accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= accept;
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      patched_q <= patched_i;
      insn_q    <= insn_word_i;
      pc_q      <= source_pc_i;
    end
    if (req_valid_q) begin
      kind_q   <= kind_d;
      target_q <= target_d;
    end
  end

  atcfc_decode u_decode (
    .cmd_i       (cmd_q),
    .patched_i   (patched_q),
    .insn_word_i (insn_q),
    .kind_o      (kind_d)
  );

  atcfc_target u_target (
    .cmd_i       (cmd_q),
    .patched_i   (patched_q),
    .insn_word_i (insn_q),
    .source_pc_i (pc_q),
    .kind_i      (kind_d),
    .target_o    (target_d)
  );

  assign done_o          = res_valid_q;
  assign event_kind_o    = kind_q;
  assign branch_target_o = target_q;

`ifndef SYNTHESIS
  a_done_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result strobe without a request two cycles earlier");

  a_target_only_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && branch_target_o != 32'd0) |->
      (event_kind_o == KIND_ARM_B || event_kind_o == KIND_ARM_BL ||
       event_kind_o == KIND_THUMB_B || event_kind_o == KIND_THUMB_BCOND))
    else $error("branch target on a non-direct kind");

  a_thumb_target_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && branch_target_o != 32'd0 &&
     (event_kind_o == KIND_THUMB_B || event_kind_o == KIND_THUMB_BCOND))
      |-> branch_target_o[0])
    else $error("thumb target without bit 0 set");

  a_target_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && branch_target_o != 32'd0) |->
      !(branch_target_o[31:27] == 5'b00001 &&
        (branch_target_o[26:25] == 2'b01 || branch_target_o[26:25] == 2'b10)))
    else $error("branch target left in a ROM mirror");
`endif

endmodule

`default_nettype wire
